@@ rtl/stpp_pkg.sv @@
// Shared widths, types and constants for the straight-track plane projector.
package stpp_pkg;

    localparam int ROOT_W       = 31;
    localparam int RAD_W        = 2 * ROOT_W;
    localparam int QUO_W        = 17;
    localparam int DVD_W        = 46;
    localparam int CORDIC_STEPS = 30;
    localparam int CX_W         = 36;
    localparam int CZ_W         = 34;

    localparam logic [31:0] PI_Q30    = 32'hC90FDAA2;
    localparam logic [14:0] ANGLE_PI  = 15'd25736;

    typedef enum logic [1:0] {
        CFG_Z_FIRST   = 2'd0,
        CFG_Z_SECOND  = 2'd1,
        CFG_Z_TIMING  = 2'd2,
        CFG_TOF_SCALE = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [23:0] f_x;
        logic signed [23:0] f_y;
        logic signed [23:0] s_x;
        logic signed [23:0] s_y;
        logic signed [23:0] t_x;
        logic signed [23:0] t_y;
    } hits_t;

    typedef struct packed {
        hits_t              hits;
        logic signed [24:0] lx;
        logic signed [24:0] ly;
        logic signed [20:0] lz;
    } path_t;

    typedef struct packed {
        hits_t             hits;
        logic              zero;
        logic [ROOT_W-1:0] mag;
        logic [2:0]        neg;
    } tail_t;

    localparam logic [29:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
        30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
        30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
    };

endpackage

@@ rtl/stpp_isqrt.sv @@
// Pipelined integer square root, one root bit per stage.
module stpp_isqrt (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [stpp_pkg::RAD_W-1:0]  rad_i,
    output logic [stpp_pkg::ROOT_W-1:0] root_o
);

    localparam int N     = stpp_pkg::ROOT_W;
    localparam int RW    = stpp_pkg::RAD_W;
    localparam int REM_W = N + 2;

    logic [REM_W-1:0] rem_reg   [0:N-1];
    logic [N-1:0]     root_reg  [0:N-1];
    logic [RW-1:0]    rad_reg   [0:N-1];
    logic [REM_W-1:0] rem_next  [0:N-1];
    logic [N-1:0]     root_next [0:N-1];
    logic [RW-1:0]    rad_next  [0:N-1];
    logic [REM_W-1:0] rem_src   [0:N-1];
    logic [N-1:0]     root_src  [0:N-1];
    logic [RW-1:0]    rad_src   [0:N-1];

    always_comb begin
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        rem_src[0]  = '0;
        root_src[0] = '0;
        rad_src[0]  = rad_i;
        for (int k = 1; k < N; k++) begin
            rem_src[k]  = rem_reg[k-1];
            root_src[k] = root_reg[k-1];
            rad_src[k]  = rad_reg[k-1];
        end
        for (int k = 0; k < N; k++) begin
            cur   = {rem_src[k][N-1:0], rad_src[k][RW-1 -: 2]};
            trial = {root_src[k], 2'b01};
            if (cur >= trial) begin
                rem_next[k]  = cur - trial;
                root_next[k] = {root_src[k][N-2:0], 1'b1};
            end else begin
                rem_next[k]  = cur;
                root_next[k] = {root_src[k][N-2:0], 1'b0};
            end
            rad_next[k] = {rad_src[k][RW-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_next[k];
            end
        end
    end

    assign root_o = root_reg[N-1];

endmodule

@@ rtl/stpp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module stpp_div (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [stpp_pkg::DVD_W-1:0]  dvd_i,
    input  logic [stpp_pkg::ROOT_W-1:0] den_i,
    output logic [stpp_pkg::QUO_W-1:0]  quo_o
);

    localparam int N  = stpp_pkg::ROOT_W;
    localparam int QW = stpp_pkg::QUO_W;
    localparam int DW = stpp_pkg::DVD_W;

    logic [N-1:0]  rem_reg  [0:QW-1];
    logic [N-1:0]  den_reg  [0:QW-1];
    logic [QW-1:0] lo_reg   [0:QW-1];
    logic [QW-1:0] q_reg    [0:QW-1];
    logic [N-1:0]  rem_next [0:QW-1];
    logic [QW-1:0] lo_next  [0:QW-1];
    logic [QW-1:0] q_next   [0:QW-1];
    logic [N-1:0]  rem_src  [0:QW-1];
    logic [N-1:0]  den_src  [0:QW-1];
    logic [QW-1:0] lo_src   [0:QW-1];
    logic [QW-1:0] q_src    [0:QW-1];

    always_comb begin
        logic [N:0] cur;
        rem_src[0] = N'(dvd_i[DW-1:QW]);
        den_src[0] = den_i;
        lo_src[0]  = dvd_i[QW-1:0];
        q_src[0]   = '0;
        for (int k = 1; k < QW; k++) begin
            rem_src[k] = rem_reg[k-1];
            den_src[k] = den_reg[k-1];
            lo_src[k]  = lo_reg[k-1];
            q_src[k]   = q_reg[k-1];
        end
        for (int k = 0; k < QW; k++) begin
            cur = {rem_src[k], lo_src[k][QW-1]};
            if (cur >= {1'b0, den_src[k]}) begin
                rem_next[k] = N'(cur - {1'b0, den_src[k]});
                q_next[k]   = {q_src[k][QW-2:0], 1'b1};
            end else begin
                rem_next[k] = cur[N-1:0];
                q_next[k]   = {q_src[k][QW-2:0], 1'b0};
            end
            lo_next[k] = {lo_src[k][QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < QW; k++) begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_src[k];
                lo_reg[k]  <= lo_next[k];
                q_reg[k]   <= q_next[k];
            end
        end
    end

    assign quo_o = q_reg[QW-1];

endmodule

@@ rtl/straight_track_plane_projector_top.sv @@
// Throughput: one transaction per cycle; the 31-stage square roots and the
// 30-stage CORDIC are fully pipelined. A stalled output freezes all stages.
// Reset (aresetn low, synchronous) clears the plane and scale registers and
// all stage valid bits.
module straight_track_plane_projector_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // x_slope, x_offset, y_slope, y_offset
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [231:0] m_tdata,   // first_hit_x, first_hit_y, second_hit_x,
                                    // second_hit_y, timing_hit_x, timing_hit_y,
                                    // unit_dir_x, unit_dir_y, unit_dir_z,
                                    // polar_angle, flight_time, zero pad
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_wdata
);

    localparam int SQRT_LAT = stpp_pkg::ROOT_W;
    localparam int DIV_LAT  = stpp_pkg::QUO_W;
    localparam int CN       = stpp_pkg::CORDIC_STEPS;
    localparam int QDLY     = CN - DIV_LAT;
    localparam int LAT      = 5 + SQRT_LAT + 1 + CN + 3;
    localparam int RW       = stpp_pkg::ROOT_W;
    localparam int XW       = stpp_pkg::CX_W;
    localparam int ZW       = stpp_pkg::CZ_W;

    logic [19:0]    z_first_reg, z_second_reg, z_timing_reg;
    logic [23:0]    tof_scale_reg;
    logic           en;
    logic [LAT-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            z_first_reg   <= '0;
            z_second_reg  <= '0;
            z_timing_reg  <= '0;
            tof_scale_reg <= '0;
        end else if (cfg_wr_en) begin
            case (stpp_pkg::cfg_index_t'(cfg_index))
                stpp_pkg::CFG_Z_FIRST:   z_first_reg   <= cfg_wdata[19:0];
                stpp_pkg::CFG_Z_SECOND:  z_second_reg  <= cfg_wdata[19:0];
                stpp_pkg::CFG_Z_TIMING:  z_timing_reg  <= cfg_wdata[19:0];
                stpp_pkg::CFG_TOF_SCALE: tof_scale_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en && aresetn;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    function automatic logic signed [23:0] proj(input logic signed [44:0] p,
                                                input logic signed [23:0] off);
        logic signed [44:0] r;
        logic signed [25:0] sum;
        r   = p + 45'sd524288;
        sum = 26'(r >>> 20) + 26'(off);
        if (sum > 26'sd8388607)
            return 24'sh7FFFFF;
        else if (sum < -26'sd8388608)
            return 24'sh800000;
        else
            return sum[23:0];
    endfunction

    function automatic logic [15:0] unitv(input logic [16:0] q, input logic neg);
        logic [16:0] r;
        if (neg) begin
            r = (q > 17'd32768) ? 17'd32768 : q;
            return 16'(17'd0 - r);
        end else begin
            return (q > 17'd32767) ? 16'h7FFF : q[15:0];
        end
    endfunction

    // stage A: slope times plane z
    logic signed [23:0] xs, xo, ys, yo;
    logic signed [20:0] zf, zs, zt;
    logic signed [44:0] prod_reg [0:5];
    logic signed [23:0] xo_reg, yo_reg;

    assign xs = s_tdata[23:0];
    assign xo = s_tdata[47:24];
    assign ys = s_tdata[71:48];
    assign yo = s_tdata[95:72];
    assign zf = $signed({1'b0, z_first_reg});
    assign zs = $signed({1'b0, z_second_reg});
    assign zt = $signed({1'b0, z_timing_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg[0] <= xs * zf;
            prod_reg[1] <= ys * zf;
            prod_reg[2] <= xs * zs;
            prod_reg[3] <= ys * zs;
            prod_reg[4] <= xs * zt;
            prod_reg[5] <= ys * zt;
            xo_reg      <= xo;
            yo_reg      <= yo;
        end
    end

    // stage B: hit positions
    stpp_pkg::hits_t hits_b_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            hits_b_reg.f_x <= proj(prod_reg[0], xo_reg);
            hits_b_reg.f_y <= proj(prod_reg[1], yo_reg);
            hits_b_reg.s_x <= proj(prod_reg[2], xo_reg);
            hits_b_reg.s_y <= proj(prod_reg[3], yo_reg);
            hits_b_reg.t_x <= proj(prod_reg[4], xo_reg);
            hits_b_reg.t_y <= proj(prod_reg[5], yo_reg);
        end
    end

    // stage C: path vector
    stpp_pkg::path_t path_c_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            path_c_reg.hits <= hits_b_reg;
            path_c_reg.lx   <= 25'(hits_b_reg.t_x) - 25'(hits_b_reg.f_x);
            path_c_reg.ly   <= 25'(hits_b_reg.t_y) - 25'(hits_b_reg.f_y);
            path_c_reg.lz   <= zt - zf;
        end
    end

    // stage D: squares
    stpp_pkg::path_t path_d_reg;
    logic [49:0]     sqx_reg, sqy_reg;
    logic [41:0]     sqz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            path_d_reg <= path_c_reg;
            sqx_reg    <= path_c_reg.lx * path_c_reg.lx;
            sqy_reg    <= path_c_reg.ly * path_c_reg.ly;
            sqz_reg    <= path_c_reg.lz * path_c_reg.lz;
        end
    end

    // stage E: sums of squares
    stpp_pkg::path_t path_e_reg;
    logic [49:0]     rho2_reg, s_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            path_e_reg <= path_d_reg;
            rho2_reg   <= sqx_reg + sqy_reg;
            s_reg      <= sqx_reg + sqy_reg + 50'(sqz_reg);
        end
    end

    // square roots
    logic [RW-1:0]   mag, rho;
    stpp_pkg::path_t path_dly_reg [0:SQRT_LAT-1];
    stpp_pkg::path_t pth;

    stpp_isqrt u_sqrt_mag (
        .aclk   (aclk),
        .en     (en),
        .rad_i  ({s_reg, 12'b0}),
        .root_o (mag)
    );

    stpp_isqrt u_sqrt_rho (
        .aclk   (aclk),
        .en     (en),
        .rad_i  ({rho2_reg, 12'b0}),
        .root_o (rho)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            path_dly_reg[0] <= path_e_reg;
            for (int i = 1; i < SQRT_LAT; i++)
                path_dly_reg[i] <= path_dly_reg[i-1];
        end
    end

    assign pth = path_dly_reg[SQRT_LAT-1];

    // stage F: dividends and CORDIC start vector
    logic [24:0]                     ax, ay;
    logic [20:0]                     az;
    logic signed [XW-1:0]            cx_init, cy_init;
    logic [stpp_pkg::DVD_W-1:0]      dvd_f_reg [0:2];
    stpp_pkg::tail_t                 tail_f_reg;
    logic signed [XW-1:0]            cx_f_reg, cy_f_reg;
    logic signed [ZW-1:0]            cz_f_reg;

    assign ax      = pth.lx[24] ? 25'(-pth.lx) : 25'(pth.lx);
    assign ay      = pth.ly[24] ? 25'(-pth.ly) : 25'(pth.ly);
    assign az      = pth.lz[20] ? 21'(-pth.lz) : 21'(pth.lz);
    assign cx_init = {{9{pth.lz[20]}}, pth.lz, 6'b0};
    assign cy_init = {5'b0, rho};

    always_ff @(posedge aclk) begin
        if (en) begin
            dvd_f_reg[0]    <= {1'b0, ax[23:0], 21'b0} + stpp_pkg::DVD_W'(mag >> 1);
            dvd_f_reg[1]    <= {1'b0, ay[23:0], 21'b0} + stpp_pkg::DVD_W'(mag >> 1);
            dvd_f_reg[2]    <= {5'b0, az[19:0], 21'b0} + stpp_pkg::DVD_W'(mag >> 1);
            tail_f_reg.hits <= pth.hits;
            tail_f_reg.zero <= (mag == '0);
            tail_f_reg.mag  <= mag;
            tail_f_reg.neg  <= {pth.lz[20], pth.ly[24], pth.lx[24]};
            if (pth.lz[20]) begin
                cx_f_reg <= cy_init;
                cy_f_reg <= -cx_init;
                cz_f_reg <= 34'sh040000000;
            end else begin
                cx_f_reg <= cx_init;
                cy_f_reg <= cy_init;
                cz_f_reg <= '0;
            end
        end
    end

    // unit direction dividers
    logic [2:0][stpp_pkg::QUO_W-1:0] quo;
    logic [2:0][stpp_pkg::QUO_W-1:0] q_dly_reg [0:QDLY-1];

    for (genvar g = 0; g < 3; g++) begin : g_div
        stpp_div u_div (
            .aclk  (aclk),
            .en    (en),
            .dvd_i (dvd_f_reg[g]),
            .den_i (tail_f_reg.mag),
            .quo_o (quo[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_dly_reg[0] <= quo;
            for (int i = 1; i < QDLY; i++)
                q_dly_reg[i] <= q_dly_reg[i-1];
        end
    end

    // CORDIC vectoring, one rotation per stage
    logic signed [XW-1:0] cx_reg  [0:CN-1];
    logic signed [XW-1:0] cy_reg  [0:CN-1];
    logic signed [ZW-1:0] cz_reg  [0:CN-1];
    logic signed [XW-1:0] cx_src  [0:CN-1];
    logic signed [XW-1:0] cy_src  [0:CN-1];
    logic signed [ZW-1:0] cz_src  [0:CN-1];
    logic signed [XW-1:0] cx_next [0:CN-1];
    logic signed [XW-1:0] cy_next [0:CN-1];
    logic signed [ZW-1:0] cz_next [0:CN-1];
    stpp_pkg::tail_t      tail_dly_reg [0:CN-1];

    always_comb begin
        logic signed [ZW-1:0] at;
        cx_src[0] = cx_f_reg;
        cy_src[0] = cy_f_reg;
        cz_src[0] = cz_f_reg;
        for (int i = 1; i < CN; i++) begin
            cx_src[i] = cx_reg[i-1];
            cy_src[i] = cy_reg[i-1];
            cz_src[i] = cz_reg[i-1];
        end
        for (int i = 0; i < CN; i++) begin
            at = $signed({4'b0, stpp_pkg::ATAN_TURNS[i]});
            if (!cy_src[i][XW-1]) begin
                cx_next[i] = cx_src[i] + (cy_src[i] >>> i);
                cy_next[i] = cy_src[i] - (cx_src[i] >>> i);
                cz_next[i] = cz_src[i] + at;
            end else begin
                cx_next[i] = cx_src[i] - (cy_src[i] >>> i);
                cy_next[i] = cy_src[i] + (cx_src[i] >>> i);
                cz_next[i] = cz_src[i] - at;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < CN; i++) begin
                cx_reg[i] <= cx_next[i];
                cy_reg[i] <= cy_next[i];
                cz_reg[i] <= cz_next[i];
            end
            tail_dly_reg[0] <= tail_f_reg;
            for (int i = 1; i < CN; i++)
                tail_dly_reg[i] <= tail_dly_reg[i-1];
        end
    end

    // stage G: clamp angle, scale products, saturate unit vector
    stpp_pkg::tail_t    tl;
    logic signed [34:0] pdiff;
    logic [31:0]        p_g_reg;
    logic [54:0]        tofp_g_reg;
    logic [2:0][15:0]   unit_g_reg;
    stpp_pkg::hits_t    hits_g_reg;
    logic               zero_g_reg;

    assign tl    = tail_dly_reg[CN-1];
    assign pdiff = $signed(35'h080000000) - 35'(cz_reg[CN-1]);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (pdiff[34])
                p_g_reg <= '0;
            else if (pdiff > 35'sh080000000)
                p_g_reg <= 32'h80000000;
            else
                p_g_reg <= pdiff[31:0];
            tofp_g_reg    <= tl.mag * tof_scale_reg;
            unit_g_reg[0] <= unitv(q_dly_reg[QDLY-1][0], tl.neg[0]);
            unit_g_reg[1] <= unitv(q_dly_reg[QDLY-1][1], tl.neg[1]);
            unit_g_reg[2] <= unitv(q_dly_reg[QDLY-1][2], tl.neg[2]);
            hits_g_reg    <= tl.hits;
            zero_g_reg    <= tl.zero;
        end
    end

    // stage H: angle to radians, flight time rounding
    logic [55:0]      tof_sum;
    logic [29:0]      tof_q;
    logic [63:0]      angp_h_reg;
    logic [23:0]      tof_h_reg;
    logic [2:0][15:0] unit_h_reg;
    stpp_pkg::hits_t  hits_h_reg;
    logic             zero_h_reg;

    assign tof_sum = {1'b0, tofp_g_reg} + 56'h2000000;
    assign tof_q   = tof_sum[55:26];

    always_ff @(posedge aclk) begin
        if (en) begin
            angp_h_reg <= p_g_reg * stpp_pkg::PI_Q30;
            tof_h_reg  <= (tof_q > 30'hFFFFFF) ? 24'hFFFFFF : tof_q[23:0];
            unit_h_reg <= unit_g_reg;
            hits_h_reg <= hits_g_reg;
            zero_h_reg <= zero_g_reg;
        end
    end

    // stage I: output register
    logic [63:0]  ang_sum;
    logic [231:0] out_reg;

    assign ang_sum = angp_h_reg + 64'h0000800000000000;

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg[23:0]    <= hits_h_reg.f_x;
            out_reg[47:24]   <= hits_h_reg.f_y;
            out_reg[71:48]   <= hits_h_reg.s_x;
            out_reg[95:72]   <= hits_h_reg.s_y;
            out_reg[119:96]  <= hits_h_reg.t_x;
            out_reg[143:120] <= hits_h_reg.t_y;
            out_reg[231]     <= 1'b0;
            if (zero_h_reg) begin
                out_reg[191:144] <= '0;
                out_reg[206:192] <= stpp_pkg::ANGLE_PI;
                out_reg[230:207] <= '0;
            end else begin
                out_reg[159:144] <= unit_h_reg[0];
                out_reg[175:160] <= unit_h_reg[1];
                out_reg[191:176] <= unit_h_reg[2];
                out_reg[206:192] <= ang_sum[62:48];
                out_reg[230:207] <= tof_h_reg;
            end
        end
    end

    assign m_tdata = out_reg;

endmodule

@@ bench/tb_straight_track_plane_projector_top.sv @@
// Testbench for the straight-track plane projector: directed and random tracks, self-checked.
`timescale 1ns / 1ps

module tb_straight_track_plane_projector_top;

    typedef struct packed {
        logic [23:0] flight_time;
        logic [14:0] polar_angle;
        logic [15:0] unit_dir_z;
        logic [15:0] unit_dir_y;
        logic [15:0] unit_dir_x;
        logic [23:0] timing_hit_y;
        logic [23:0] timing_hit_x;
        logic [23:0] second_hit_y;
        logic [23:0] second_hit_x;
        logic [23:0] first_hit_y;
        logic [23:0] first_hit_x;
    } proj_t;

    localparam int LATENCY = 70;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [231:0] m_tdata;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_index = stpp_pkg::CFG_Z_FIRST;
    logic [23:0]  cfg_wdata = '0;

    proj_t   expected_q[$];
    int      errors = 0;
    bit      calm = 1'b0;
    longint  z_first, z_second, z_timing, scale;

    straight_track_plane_projector_top dut (.*);

    initial forever #1 aclk = ~aclk;

    initial begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint plane_hit(longint slope, longint offset, longint z);
        return clamp(floor_shr(slope * z + (64'sd1 <<< 19), 20) + offset,
                     -8388608, 8388607);
    endfunction

    function automatic longint direction(longint d, longint unsigned mag);
        longint unsigned a, q;
        longint r;
        a = longint'(d < 0 ? -d : d) << 21;
        q = (a + mag / 2) / mag;
        r = q > 32768 ? 32768 : q;
        return clamp(d < 0 ? -r : r, -32768, 32767);
    endfunction

    function automatic proj_t project_track(logic [95:0] trk);
        proj_t  o;
        longint xs, xo, ys, yo, fx, fy, sx, sy, tx, ty, lx, ly, lz;
        longint cx, cy, cz, dx, dy, p;
        longint unsigned rho2, s, mag, t;
        xs = longint'($signed(trk[23:0]));
        xo = longint'($signed(trk[47:24]));
        ys = longint'($signed(trk[71:48]));
        yo = longint'($signed(trk[95:72]));
        fx = plane_hit(xs, xo, z_first);   fy = plane_hit(ys, yo, z_first);
        sx = plane_hit(xs, xo, z_second);  sy = plane_hit(ys, yo, z_second);
        tx = plane_hit(xs, xo, z_timing);  ty = plane_hit(ys, yo, z_timing);
        lx = tx - fx;
        ly = ty - fy;
        lz = z_timing - z_first;
        rho2 = lx * lx + ly * ly;
        s = rho2 + lz * lz;
        o = '0;
        o.polar_angle = stpp_pkg::ANGLE_PI;
        if (s != 0) begin
            mag = int_sqrt(s << 12);
            o.unit_dir_x = 16'(direction(lx, mag));
            o.unit_dir_y = 16'(direction(ly, mag));
            o.unit_dir_z = 16'(direction(lz, mag));
            cx = lz * 64;
            cy = int_sqrt(rho2 << 12);
            cz = 0;
            if (cx < 0) begin
                p = cx;
                cx = cy;
                cy = -p;
                cz = 64'h40000000;
            end
            for (int i = 0; i < stpp_pkg::CORDIC_STEPS; i++) begin
                dx = floor_shr(cy, i);
                dy = floor_shr(cx, i);
                if (cy >= 0) begin
                    cx += dx; cy -= dy; cz += longint'(stpp_pkg::ATAN_TURNS[i]);
                end else begin
                    cx -= dx; cy += dy; cz -= longint'(stpp_pkg::ATAN_TURNS[i]);
                end
            end
            p = clamp(64'sh80000000 - cz, 0, 64'sh80000000);
            o.polar_angle = 15'((longint'(p) * longint'(stpp_pkg::PI_Q30)
                                 + (64'd1 << 47)) >> 48);
            t = (mag * scale + (64'd1 << 25)) >> 26;
            o.flight_time = 24'(t > 24'hFFFFFF ? 24'hFFFFFF : t);
        end
        o.first_hit_x = 24'(fx);  o.first_hit_y = 24'(fy);
        o.second_hit_x = 24'(sx); o.second_hit_y = 24'(sy);
        o.timing_hit_x = 24'(tx); o.timing_hit_y = 24'(ty);
        return o;
    endfunction

    task automatic write_reg(stpp_pkg::cfg_index_t idx, logic [23:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            stpp_pkg::CFG_Z_FIRST:   z_first  = val[19:0];
            stpp_pkg::CFG_Z_SECOND:  z_second = val[19:0];
            stpp_pkg::CFG_Z_TIMING:  z_timing = val[19:0];
            stpp_pkg::CFG_TOF_SCALE: scale    = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (LATENCY + 5) @(negedge aclk);
    endtask

    task automatic set_planes(logic [19:0] zf, logic [19:0] zs, logic [19:0] zt,
                              logic [23:0] sc);
        drain();
        write_reg(stpp_pkg::CFG_Z_FIRST, 24'(zf));
        write_reg(stpp_pkg::CFG_Z_SECOND, 24'(zs));
        write_reg(stpp_pkg::CFG_Z_TIMING, 24'(zt));
        write_reg(stpp_pkg::CFG_TOF_SCALE, sc);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    // with s_tvalid still high
    task automatic send_track(logic [23:0] xs, logic [23:0] xo,
                              logic [23:0] ys, logic [23:0] yo);
        while (!calm && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {yo, ys, xo, xs};
        do @(posedge aclk); while (!s_tready);
        expected_q.push_back(project_track({yo, ys, xo, xs}));
        @(negedge aclk);
    endtask

    task automatic send_random(int n);
        logic [23:0] xs, xo, ys, yo;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: begin xs = 24'($urandom); ys = 24'($urandom); end
                default: begin
                    xs = $signed(24'($urandom_range(2097152))) - 24'sd1048576;
                    ys = $signed(24'($urandom_range(2097152))) - 24'sd1048576;
                end
            endcase
            xo = 24'($urandom);
            yo = 24'($urandom);
            if ($urandom_range(9) == 0) xo = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            send_track(xs, xo, ys, yo);
        end
    endtask

    always @(negedge aclk) m_tready <= calm || ($urandom_range(99) >= 27);

    always @(posedge aclk) begin
        proj_t got, exp;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[230:0];
            if (expected_q.size() == 0) begin
                $error("unexpected result transaction %h", got);
                errors++;
            end else begin
                exp = expected_q.pop_front();
                if (got.first_hit_x !== exp.first_hit_x) begin
                    $error("first_hit_x exp %h got %h", exp.first_hit_x, got.first_hit_x);
                    errors++;
                end
                if (got.first_hit_y !== exp.first_hit_y) begin
                    $error("first_hit_y exp %h got %h", exp.first_hit_y, got.first_hit_y);
                    errors++;
                end
                if (got.second_hit_x !== exp.second_hit_x) begin
                    $error("second_hit_x exp %h got %h", exp.second_hit_x, got.second_hit_x);
                    errors++;
                end
                if (got.second_hit_y !== exp.second_hit_y) begin
                    $error("second_hit_y exp %h got %h", exp.second_hit_y, got.second_hit_y);
                    errors++;
                end
                if (got.timing_hit_x !== exp.timing_hit_x) begin
                    $error("timing_hit_x exp %h got %h", exp.timing_hit_x, got.timing_hit_x);
                    errors++;
                end
                if (got.timing_hit_y !== exp.timing_hit_y) begin
                    $error("timing_hit_y exp %h got %h", exp.timing_hit_y, got.timing_hit_y);
                    errors++;
                end
                if (got.unit_dir_x !== exp.unit_dir_x) begin
                    $error("unit_dir_x exp %h got %h", exp.unit_dir_x, got.unit_dir_x);
                    errors++;
                end
                if (got.unit_dir_y !== exp.unit_dir_y) begin
                    $error("unit_dir_y exp %h got %h", exp.unit_dir_y, got.unit_dir_y);
                    errors++;
                end
                if (got.unit_dir_z !== exp.unit_dir_z) begin
                    $error("unit_dir_z exp %h got %h", exp.unit_dir_z, got.unit_dir_z);
                    errors++;
                end
                if (got.polar_angle !== exp.polar_angle) begin
                    $error("polar_angle exp %h got %h", exp.polar_angle, got.polar_angle);
                    errors++;
                end
                if (got.flight_time !== exp.flight_time) begin
                    $error("flight_time exp %h got %h", exp.flight_time, got.flight_time);
                    errors++;
                end
            end
        end
    end

    task automatic test_reset_planes();
        // all planes at zero: null path
        send_track(24'h100000, 24'h000010, 24'h7FFFFF, 24'h800000);
        send_track(24'h800000, 24'h7FFFFF, 24'h000000, 24'h000000);
    endtask

    task automatic test_directed();
        set_planes(20'd1600, 20'd3200, 20'd16000, 24'd1048576);
        send_track(24'h000000, 24'h000000, 24'h000000, 24'h000000); // straight on axis
        send_track(24'h000000, 24'h7FFFFF, 24'h000000, 24'h800000); // offsets extreme
        send_track(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF); // saturate high
        send_track(24'h800000, 24'h800000, 24'h800000, 24'h800000); // saturate low
        send_track(24'h080000, 24'h000008, 24'hF80000, 24'hFFFFF8); // slopes of plus and minus one half
        send_track(24'h100000, 24'h000000, 24'hF00000, 24'h000000);
        // backward path, Lz negative
        set_planes(20'hFFFFF, 20'd8000, 20'd0, 24'hFFFFFF);
        send_track(24'h000000, 24'h000000, 24'h000000, 24'h000000);
        send_track(24'h7FFFFF, 24'h123456, 24'h800000, 24'hABCDEF);
        send_track(24'h010000, 24'h000000, 24'hFF0000, 24'h000000);
        // Lz zero but transverse motion impossible: null path with scale
        set_planes(20'd5000, 20'hFFFFF, 20'd5000, 24'hFFFFFF);
        send_track(24'h7FFFFF, 24'h000000, 24'h800000, 24'h000000);
        send_track(24'h000000, 24'h7FFFFF, 24'h000000, 24'h800000);
    endtask

    task automatic test_random();
        set_planes(20'd800, 20'd1600, 20'd40000, 24'd900000);
        send_random(150);
        // hold off until the pipeline is empty
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        calm = 1'b1;
        send_random(100);
        calm = 1'b0;
        set_planes(20'($urandom), 20'($urandom), 20'($urandom), 24'($urandom));
        send_random(150);
        set_planes(20'hFFFFF, 20'd0, 20'd0, 24'd0);
        send_random(100);
        set_planes(20'($urandom_range(2000)), 20'($urandom), 20'hFFFFF, 24'hFFFFFF);
        send_random(150);
    endtask

    initial begin
        z_first = 0; z_second = 0; z_timing = 0; scale = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_planes();
        test_directed();
        test_random();
        drain();
        if (errors == 0 && expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
